/* src/nlse_pkg.sv */
// Shared types and constants for the nonconforming linear shape evaluator.
package nlse_pkg;

  // Coordinate and result words are signed fixed point of this width
  localparam int DATA_W = 32;
  localparam int VERTS = 4;
  localparam int DOF_COUNT = 4;
  localparam int DOF_W = 2;

  // Internal widths, from the input range
  localparam int DIFF_W = 34;   // doubled midpoint differences
  localparam int OFS_W = 36;    // four times point offset from center
  localparam int NRM_W = 35;    // gradient numerators
  localparam int PROD_W = 68;   // a*b, c*d
  localparam int DET_W = 69;    // determinant
  localparam int MUL_W = 70;    // numerator times offset
  localparam int NUM_W = 72;    // value numerator
  localparam int DEN_W = 72;    // divisor magnitude
  localparam int QUO_W = DATA_W - 1;

  // Divider lanes
  localparam int LANES = 3;
  localparam int LANE_VAL = 0;
  localparam int LANE_GX = 1;
  localparam int LANE_GY = 2;

  // Configuration port
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE_VALUES    = 1'b0,
    REG_ENABLE_GRADIENTS = 1'b1
  } cfg_reg_t;

  localparam logic [DATA_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] SAT_NEG = 32'h8000_0000;

  // Per-result side information that rides with the data
  typedef struct packed {
    logic [DOF_W-1:0] dof;
    logic             last;
    logic             degen;
  } tag_t;

endpackage

/* src/nlse_if.sv */
// Input and result channel interfaces.
interface nlse_in_if;
  import nlse_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] vertex0_x;
  logic signed [DATA_W-1:0] vertex0_y;
  logic signed [DATA_W-1:0] vertex1_x;
  logic signed [DATA_W-1:0] vertex1_y;
  logic signed [DATA_W-1:0] vertex2_x;
  logic signed [DATA_W-1:0] vertex2_y;
  logic signed [DATA_W-1:0] vertex3_x;
  logic signed [DATA_W-1:0] vertex3_y;
  logic signed [DATA_W-1:0] point_x;
  logic signed [DATA_W-1:0] point_y;

  modport source (output valid, vertex0_x, vertex0_y, vertex1_x, vertex1_y, vertex2_x,
                  vertex2_y, vertex3_x, vertex3_y, point_x, point_y, input ready);
  modport sink (input valid, vertex0_x, vertex0_y, vertex1_x, vertex1_y, vertex2_x,
                vertex2_y, vertex3_x, vertex3_y, point_x, point_y, output ready);
endinterface

interface nlse_out_if;
  import nlse_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [DOF_W-1:0]         dof_index;
  logic signed [DATA_W-1:0] shape_value;
  logic signed [DATA_W-1:0] grad_x;
  logic signed [DATA_W-1:0] grad_y;
  logic                     degenerate;
  logic                     last;

  modport source (output valid, dof_index, shape_value, grad_x, grad_y, degenerate, last,
                  input ready);
  modport sink (input valid, dof_index, shape_value, grad_x, grad_y, degenerate, last,
                output ready);
endinterface

/* src/nonconforming_linear_shape_eval_unit.sv */
// Top level: P1 nonconforming quadrilateral shape function evaluator.
// Each item leaves as four result words, one word per cycle while result.ready is high.
// The single result port carries four words per item; a new item can enter meanwhile.
// The divider is a 33-stage pipeline, one quotient bit per stage, three lanes.
// Reset: synchronous; clears valid bits and sets both enable registers to 1.
module nonconforming_linear_shape_eval_unit import nlse_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  nlse_in_if.sink               item,
  nlse_out_if.source            result
);

  localparam int NUM_MAG_W = NUM_W + FRAC_BITS + 2;

  logic en_values, en_gradients;

  logic signed [DATA_W-1:0] vx [VERTS];
  logic signed [DATA_W-1:0] vy [VERTS];

  logic                     f_valid, take;
  logic signed [DIFF_W-1:0] fa, fb, fc, fd;
  logic signed [OFS_W-1:0]  fex, fey;
  logic signed [DET_W-1:0]  fdet;

  logic                 p_valid, p_ready;
  logic [NUM_MAG_W-1:0] p_num [LANES];
  logic [DEN_W-1:0]     p_den [LANES];
  logic [LANES-1:0]     p_neg, p_zero;
  tag_t                 p_tag;

  logic [DATA_W-1:0] res [LANES];
  tag_t              r_tag;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      en_values    <= 1'b1;
      en_gradients <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ENABLE_VALUES:    en_values    <= cfg_data[0];
        REG_ENABLE_GRADIENTS: en_gradients <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign vx[0] = item.vertex0_x;
  assign vy[0] = item.vertex0_y;
  assign vx[1] = item.vertex1_x;
  assign vy[1] = item.vertex1_y;
  assign vx[2] = item.vertex2_x;
  assign vy[2] = item.vertex2_y;
  assign vx[3] = item.vertex3_x;
  assign vy[3] = item.vertex3_y;

  nlse_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .vx        (vx),
    .vy        (vy),
    .px        (item.point_x),
    .py        (item.point_y),
    .take      (take),
    .out_valid (f_valid),
    .a         (fa),
    .b         (fb),
    .c         (fc),
    .d         (fd),
    .ex        (fex),
    .ey        (fey),
    .det       (fdet)
  );

  nlse_dof #(
    .FRAC_BITS (FRAC_BITS),
    .NW        (NUM_MAG_W)
  ) u_dof (
    .clk          (clk),
    .rst          (rst),
    .en_values    (en_values),
    .en_gradients (en_gradients),
    .in_valid     (f_valid),
    .take         (take),
    .a            (fa),
    .b            (fb),
    .c            (fc),
    .d            (fd),
    .ex           (fex),
    .ey           (fey),
    .det          (fdet),
    .next_ready   (p_ready),
    .out_valid    (p_valid),
    .num_o        (p_num),
    .den_o        (p_den),
    .neg_o        (p_neg),
    .zero_o       (p_zero),
    .tag_o        (p_tag)
  );

  nlse_div #(
    .NW (NUM_MAG_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (p_valid),
    .in_ready  (p_ready),
    .num_i     (p_num),
    .den_i     (p_den),
    .neg_i     (p_neg),
    .zero_i    (p_zero),
    .tag_i     (p_tag),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .res_o     (res),
    .tag_o     (r_tag)
  );

  // result word
  assign result.dof_index   = r_tag.dof;
  assign result.last        = r_tag.last;
  assign result.degenerate  = r_tag.degen;
  assign result.shape_value = res[LANE_VAL];
  assign result.grad_x      = res[LANE_GX];
  assign result.grad_y      = res[LANE_GY];

endmodule

/* src/nlse_front.sv */
// Front pipeline: midpoint differences, products and determinant (three stages).
module nlse_front import nlse_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] vx [VERTS],
  input  logic signed [DATA_W-1:0] vy [VERTS],
  input  logic signed [DATA_W-1:0] px,
  input  logic signed [DATA_W-1:0] py,
  input  logic                     take,
  output logic                     out_valid,
  output logic signed [DIFF_W-1:0] a,
  output logic signed [DIFF_W-1:0] b,
  output logic signed [DIFF_W-1:0] c,
  output logic signed [DIFF_W-1:0] d,
  output logic signed [OFS_W-1:0]  ex,
  output logic signed [OFS_W-1:0]  ey,
  output logic signed [DET_W-1:0]  det
);

  logic v0, v1, v2;
  logic adv0, adv1, adv2;

  logic signed [DIFF_W-1:0] a_c, b_c, c_c, d_c;
  logic signed [OFS_W-1:0]  ex_c, ey_c, sx_c, sy_c;

  logic signed [DIFF_W-1:0] a0, b0, c0, d0, a1, b1, c1, d1, a2, b2, c2, d2;
  logic signed [OFS_W-1:0]  ex0, ey0, ex1, ey1, ex2, ey2;
  logic signed [PROD_W-1:0] ab1, cd1;
  logic signed [DET_W-1:0]  det2;

  // stall chain
  assign adv2 = !v2 || take;
  assign adv1 = !v1 || adv2;
  assign adv0 = !v0 || adv1;
  assign in_ready = adv0;

  // doubled midpoint differences and point offset
  always_comb begin
    a_c  = DIFF_W'(vx[0]) + DIFF_W'(vx[2]) - DIFF_W'(vx[1]) - DIFF_W'(vx[3]);
    b_c  = DIFF_W'(vy[0]) + DIFF_W'(vy[1]) - DIFF_W'(vy[2]) - DIFF_W'(vy[3]);
    c_c  = DIFF_W'(vx[0]) + DIFF_W'(vx[1]) - DIFF_W'(vx[2]) - DIFF_W'(vx[3]);
    d_c  = DIFF_W'(vy[0]) + DIFF_W'(vy[2]) - DIFF_W'(vy[1]) - DIFF_W'(vy[3]);
    sx_c = OFS_W'(vx[0]) + OFS_W'(vx[1]) + OFS_W'(vx[2]) + OFS_W'(vx[3]);
    sy_c = OFS_W'(vy[0]) + OFS_W'(vy[1]) + OFS_W'(vy[2]) + OFS_W'(vy[3]);
    ex_c = (OFS_W'(px) <<< 2) - sx_c;
    ey_c = (OFS_W'(py) <<< 2) - sy_c;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (adv0) v0 <= in_valid;
      if (adv1) v1 <= v0;
      if (adv2) v2 <= v1;
    end
  end

  // stage 0: sums
  always_ff @(posedge clk) begin
    if (adv0) begin
      a0  <= a_c;
      b0  <= b_c;
      c0  <= c_c;
      d0  <= d_c;
      ex0 <= ex_c;
      ey0 <= ey_c;
    end
  end

  // stage 1: cross products
  always_ff @(posedge clk) begin
    if (adv1) begin
      ab1 <= PROD_W'(a0) * PROD_W'(b0);
      cd1 <= PROD_W'(c0) * PROD_W'(d0);
      a1  <= a0;
      b1  <= b0;
      c1  <= c0;
      d1  <= d0;
      ex1 <= ex0;
      ey1 <= ey0;
    end
  end

  // stage 2: determinant
  always_ff @(posedge clk) begin
    if (adv2) begin
      det2 <= DET_W'(ab1) - DET_W'(cd1);
      a2   <= a1;
      b2   <= b1;
      c2   <= c1;
      d2   <= d1;
      ex2  <= ex1;
      ey2  <= ey1;
    end
  end

  assign out_valid = v2;
  assign a   = a2;
  assign b   = b2;
  assign c   = c2;
  assign d   = d2;
  assign ex  = ex2;
  assign ey  = ey2;
  assign det = det2;

endmodule

/* src/nlse_dof.sv */
// Per-DOF sequencer and numerator pipeline feeding the divider lanes.
module nlse_dof import nlse_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int NW = 90
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en_values,
  input  logic                     en_gradients,
  input  logic                     in_valid,
  output logic                     take,
  input  logic signed [DIFF_W-1:0] a,
  input  logic signed [DIFF_W-1:0] b,
  input  logic signed [DIFF_W-1:0] c,
  input  logic signed [DIFF_W-1:0] d,
  input  logic signed [OFS_W-1:0]  ex,
  input  logic signed [OFS_W-1:0]  ey,
  input  logic signed [DET_W-1:0]  det,
  input  logic                     next_ready,
  output logic                     out_valid,
  output logic [NW-1:0]            num_o [LANES],
  output logic [DEN_W-1:0]         den_o [LANES],
  output logic [LANES-1:0]         neg_o,
  output logic [LANES-1:0]         zero_o,
  output tag_t                     tag_o
);

  // sequencer holding one item
  logic                     ev;
  logic [DOF_W-1:0]         k;
  logic signed [DIFF_W-1:0] ea, eb, ec, ed;
  logic signed [OFS_W-1:0]  eex, eey;
  logic signed [DET_W-1:0]  edet;
  logic                     fire;

  logic [4:0] v;
  logic [4:0] adv;

  logic signed [NRM_W-1:0] nx_c, ny_c;
  logic signed [NRM_W-1:0] nx0, ny0, nx1, ny1, nx2, ny2;
  logic signed [OFS_W-1:0] ex0, ey0;
  logic signed [DET_W-1:0] det0, det1, det2;
  logic signed [MUL_W-1:0] mx1, my1;
  logic signed [NUM_W-1:0] num2;
  tag_t                    tag0, tag1, tag2, tag3, tag4;

  logic signed [NW-1:0]    ns_c [LANES];
  logic signed [DEN_W-1:0] ds_c [LANES];
  logic [NW-1:0]           nm3 [LANES];
  logic [DEN_W-1:0]        dm3 [LANES];
  logic [LANES-1:0]        neg3, zero3;
  logic [NW-1:0]           num4 [LANES];
  logic [DEN_W-1:0]        den4 [LANES];
  logic [LANES-1:0]        neg4, zero4;

  // stall chain
  assign adv[4] = !v[4] || next_ready;
  assign adv[3] = !v[3] || adv[4];
  assign adv[2] = !v[2] || adv[3];
  assign adv[1] = !v[1] || adv[2];
  assign adv[0] = !v[0] || adv[1];

  assign fire = ev && adv[0];
  assign take = !ev || (fire && (k == DOF_W'(DOF_COUNT - 1)));

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      ev <= 1'b0;
      k  <= '0;
    end else if (take) begin
      ev <= in_valid;
      k  <= '0;
    end else if (fire) begin
      k <= k + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ea   <= a;
      eb   <= b;
      ec   <= c;
      ed   <= d;
      eex  <= ex;
      eey  <= ey;
      edet <= det;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= ev;
      if (adv[1]) v[1] <= v[0];
      if (adv[2]) v[2] <= v[1];
      if (adv[3]) v[3] <= v[2];
      if (adv[4]) v[4] <= v[3];
    end
  end

  // gradient numerators: sign pattern p flips on odd k, q on upper k
  always_comb begin
    logic signed [NRM_W-1:0] pb, qd, qa, pc;
    pb = k[0] ? -NRM_W'(eb) : NRM_W'(eb);
    qd = k[1] ? -NRM_W'(ed) : NRM_W'(ed);
    qa = k[1] ? -NRM_W'(ea) : NRM_W'(ea);
    pc = k[0] ? -NRM_W'(ec) : NRM_W'(ec);
    nx_c = pb - qd;
    ny_c = qa - pc;
  end

  // P0: numerators per DOF
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      nx0        <= nx_c;
      ny0        <= ny_c;
      ex0        <= eex;
      ey0        <= eey;
      det0       <= edet;
      tag0.dof   <= k;
      tag0.last  <= (k == DOF_W'(DOF_COUNT - 1));
      tag0.degen <= (edet == '0);
    end
  end

  // P1: products with point offset
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      mx1  <= MUL_W'(nx0) * MUL_W'(ex0);
      my1  <= MUL_W'(ny0) * MUL_W'(ey0);
      nx1  <= nx0;
      ny1  <= ny0;
      det1 <= det0;
      tag1 <= tag0;
    end
  end

  // P2: value numerator
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      num2 <= NUM_W'(mx1) + NUM_W'(my1) + NUM_W'(det1);
      nx2  <= nx1;
      ny2  <= ny1;
      det2 <= det1;
      tag2 <= tag1;
    end
  end

  // scaled dividends and divisors
  always_comb begin
    ns_c[LANE_VAL] = NW'(num2) <<< FRAC_BITS;
    ns_c[LANE_GX]  = NW'(nx2) <<< (2 * FRAC_BITS);
    ns_c[LANE_GY]  = NW'(ny2) <<< (2 * FRAC_BITS);
    ds_c[LANE_VAL] = DEN_W'(det2) <<< 2;
    ds_c[LANE_GX]  = DEN_W'(det2);
    ds_c[LANE_GY]  = DEN_W'(det2);
  end

  // P3: magnitudes, result sign and forced-zero flags
  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int i = 0; i < LANES; i++) begin
        nm3[i]  <= ns_c[i][NW-1] ? NW'(-ns_c[i]) : NW'(ns_c[i]);
        dm3[i]  <= ds_c[i][DEN_W-1] ? DEN_W'(-ds_c[i]) : DEN_W'(ds_c[i]);
        neg3[i] <= ns_c[i][NW-1] ^ ds_c[i][DEN_W-1];
      end
      zero3[LANE_VAL] <= tag2.degen || !en_values;
      zero3[LANE_GX]  <= tag2.degen || !en_gradients;
      zero3[LANE_GY]  <= tag2.degen || !en_gradients;
      tag3 <= tag2;
    end
  end

  // P4: rounding offset, dividend 2|n|+|d| over divisor 2|d|
  always_ff @(posedge clk) begin
    if (adv[4]) begin
      for (int i = 0; i < LANES; i++) begin
        num4[i] <= (nm3[i] << 1) + NW'(dm3[i]);
        den4[i] <= dm3[i] << 1;
      end
      neg4  <= neg3;
      zero4 <= zero3;
      tag4  <= tag3;
    end
  end

  assign out_valid = v[4];
  assign num_o     = num4;
  assign den_o     = den4;
  assign neg_o     = neg4;
  assign zero_o    = zero4;
  assign tag_o     = tag4;

endmodule

/* src/nlse_div.sv */
// Pipelined restoring divider, three lanes in lockstep, one quotient bit per stage.
module nlse_div import nlse_pkg::*; #(
  parameter int NW = 90
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [NW-1:0]     num_i [LANES],
  input  logic [DEN_W-1:0]  den_i [LANES],
  input  logic [LANES-1:0]  neg_i,
  input  logic [LANES-1:0]  zero_i,
  input  tag_t              tag_i,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] res_o [LANES],
  output tag_t              tag_o
);

  localparam int LAST = QUO_W + 1;
  localparam int HW = NW - QUO_W;
  localparam int CW = (HW > DEN_W) ? HW : DEN_W;

  logic [LAST:0] v;
  logic [LAST:0] adv;

  logic [DEN_W-1:0] rem  [QUO_W+1][LANES];
  logic [DEN_W-1:0] den  [QUO_W+1][LANES];
  logic [QUO_W-1:0] lo   [QUO_W+1][LANES];
  logic [QUO_W-1:0] quo  [QUO_W+1][LANES];
  logic [LANES-1:0] neg  [QUO_W+1];
  logic [LANES-1:0] sat  [QUO_W+1];
  logic [LANES-1:0] zero [QUO_W+1];
  tag_t             tg   [QUO_W+1];

  logic [DATA_W-1:0] res [LANES];
  tag_t              tag_out;

  // a stage moves when any stage from it onward is empty or the output drains
  for (genvar i = 0; i <= LAST; i++) begin : g_adv
    assign adv[i] = out_ready || !(&v[LAST:i]);
  end
  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= in_valid;
      for (int i = 1; i <= LAST; i++) begin
        if (adv[i]) v[i] <= v[i-1];
      end
    end
  end

  // stage 0: overflow check on the top bits, seed the remainder
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int l = 0; l < LANES; l++) begin
        sat[0][l] <= CW'(num_i[l][NW-1:QUO_W]) >= CW'(den_i[l]);
        rem[0][l] <= DEN_W'(num_i[l][NW-1:QUO_W]);
        lo[0][l]  <= num_i[l][QUO_W-1:0];
        den[0][l] <= den_i[l];
        quo[0][l] <= '0;
      end
      neg[0]  <= neg_i;
      zero[0] <= zero_i;
      tg[0]   <= tag_i;
    end
  end

  // quotient bit stages
  for (genvar s = 1; s <= QUO_W; s++) begin : g_step
    always_ff @(posedge clk) begin
      if (adv[s]) begin
        for (int l = 0; l < LANES; l++) begin
          logic [DEN_W:0] rr;
          logic           ge;
          rr = {rem[s-1][l], lo[s-1][l][QUO_W-1]};
          ge = rr >= {1'b0, den[s-1][l]};
          rem[s][l] <= ge ? DEN_W'(rr - {1'b0, den[s-1][l]}) : DEN_W'(rr);
          quo[s][l] <= {quo[s-1][l][QUO_W-2:0], ge};
          lo[s][l]  <= {lo[s-1][l][QUO_W-2:0], 1'b0};
          den[s][l] <= den[s-1][l];
        end
        neg[s]  <= neg[s-1];
        sat[s]  <= sat[s-1];
        zero[s] <= zero[s-1];
        tg[s]   <= tg[s-1];
      end
    end
  end

  // output word: sign, saturation, forced zero
  always_ff @(posedge clk) begin
    if (adv[LAST]) begin
      for (int l = 0; l < LANES; l++) begin
        logic [DATA_W-1:0] qe;
        qe = {1'b0, quo[QUO_W][l]};
        if (zero[QUO_W][l])     res[l] <= '0;
        else if (sat[QUO_W][l]) res[l] <= neg[QUO_W][l] ? SAT_NEG : SAT_POS;
        else if (neg[QUO_W][l]) res[l] <= -qe;
        else                    res[l] <= qe;
      end
      tag_out <= tg[QUO_W];
    end
  end

  assign out_valid = v[LAST];
  assign res_o     = res;
  assign tag_o     = tag_out;

endmodule
